// ===== hdl/strt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strt_pkg
// Types and constants shared by the sorted task record table.
// ----------------------------------------------------------------------------
package strt_pkg;

    localparam int NAME_BYTES = 16;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_WALK   = 2'd1,
        OP_FLUSH  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        MODE_TID  = 3'd0,
        MODE_NAME = 3'd1,
        MODE_CPU  = 3'd2,
        MODE_IO   = 3'd3,
        MODE_MEM  = 3'd4
    } mode_t;

    typedef struct packed {
        logic [21:0] tid;
        logic [63:0] name_first;
        logic [63:0] name_rest;
        logic [61:0] user_time;
        logic [61:0] system_time;
        logic [61:0] read_bytes;
        logic [61:0] write_bytes;
        logic [47:0] resident_size;
    } rec_t;

    typedef struct packed {
        logic [1:0]  op;
        logic        restart;
        logic [21:0] tid;
        logic [63:0] name_first;
        logic [63:0] name_rest;
        logic [61:0] user_time;
        logic [61:0] system_time;
        logic [61:0] read_bytes;
        logic [61:0] write_bytes;
        logic [47:0] resident_size;
    } in_item_t;

    typedef struct packed {
        logic        entry_valid;
        logic        insert_dropped;
        logic [21:0] out_tid;
        logic [63:0] out_name_first;
        logic [63:0] out_name_rest;
        logic [61:0] out_user_time;
        logic [61:0] out_system_time;
        logic [61:0] out_read_bytes;
        logic [61:0] out_write_bytes;
        logic [47:0] out_resident_size;
    } out_item_t;

    // A command as queued from the front part to the back part; the key is
    // already computed for inserts in TID, CPU and IO modes.
    typedef struct packed {
        op_t         op;
        logic        restart;
        mode_t       mode;
        logic [62:0] key;
        logic [127:0] name;
        rec_t        rec;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_KEY,
        BK_SCAN,
        BK_SHIFT,
        BK_WRITE,
        BK_READ,
        BK_DONE
    } bk_state_t;

    function automatic logic [7:0] fold(input logic [7:0] c);
        fold = (c >= 8'h41 && c <= 8'h5a) ? c + 8'h20 : c;
    endfunction

    function automatic logic [127:0] fold_name(input logic [127:0] n);
        logic [127:0] r;
        for (int i = 0; i < NAME_BYTES; i++) begin
            r[i*8 +: 8] = fold(n[i*8 +: 8]);
        end
        fold_name = r;
    endfunction

    // Zero every byte after the first NUL so that plain compare matches.
    function automatic logic [127:0] trim_name(input logic [127:0] n);
        logic [127:0] r;
        logic         z;
        z = 1'b0;
        for (int i = NAME_BYTES - 1; i >= 0; i--) begin
            r[i*8 +: 8] = z ? 8'h00 : n[i*8 +: 8];
            if (n[i*8 +: 8] == 8'h00) begin
                z = 1'b1;
            end
        end
        trim_name = r;
    endfunction

endpackage

// ===== hdl/sorted_task_record_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_task_record_table
// Sorted table of task records with insert, walk and flush transactions.
// ----------------------------------------------------------------------------
// A transaction enters a two-entry command queue and is carried out by a
// sequencer that owns a record memory with one read and one write port. An
// insert scans the stored records one at a time and then moves each later
// record up one slot; in memory ratio mode the new key needs a division
// first and each compared record is divided as well.
// ----------------------------------------------------------------------------
module sorted_task_record_table #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  strt_pkg::in_item_t   in_item,
    output logic                 empty,
    input  logic                 pop,
    output strt_pkg::out_item_t  out_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_data
);
    import strt_pkg::*;

    logic [2:0] mode_reg;
    logic       cmd_valid;
    logic       cmd_take;
    cmd_t       cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= MODE_CPU;
        end else if (cfg_valid) begin
            mode_reg <= cfg_data;
        end
    end

    strt_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .sort_mode(mode_reg), .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
    );

    strt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
        .cmd(cmd), .empty(empty), .pop(pop), .out_item(out_item)
    );

endmodule

// ===== hdl/strt_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strt_div
// Restoring divider, one quotient bit per cycle, for the memory ratio key.
// ----------------------------------------------------------------------------
module strt_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] dividend,
    input  logic [62:0] divisor,
    output logic        done,
    output logic [47:0] quotient
);
    import strt_pkg::*;

    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [47:0] q_reg, q_next;
    logic [63:0] r_reg, r_next;
    logic [62:0] d_reg, d_next;
    logic        done_reg, done_next;
    logic [63:0] trial;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        done_next = 1'b0;
        trial     = {r_reg[62:0], q_reg[47]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
        end else if (busy_reg) begin
            q_next = {q_reg[46:0], 1'b0};
            if (trial >= {1'b0, d_reg}) begin
                r_next    = trial - {1'b0, d_reg};
                q_next[0] = 1'b1;
            end else begin
                r_next = trial;
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd47) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done     = done_reg;
    assign quotient = (d_reg == '0) ? '0 : q_reg;

endmodule

// ===== hdl/strt_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strt_front
// Accepts transactions, prepares keys and feeds a two-entry command queue.
// ----------------------------------------------------------------------------
module strt_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  strt_pkg::in_item_t in_item,
    input  logic [2:0]        sort_mode,
    output logic              cmd_valid,
    input  logic              cmd_take,
    output strt_pkg::cmd_t    cmd
);
    import strt_pkg::*;

    cmd_t       q_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       c;
    logic       acc;

    always_comb
    begin
        c.op      = op_t'(in_item.op);
        c.restart = in_item.restart;
        c.mode    = mode_t'(sort_mode);
        c.rec     = '{in_item.tid, in_item.name_first, in_item.name_rest,
                      in_item.user_time, in_item.system_time, in_item.read_bytes,
                      in_item.write_bytes, in_item.resident_size};
        c.name    = trim_name(fold_name({in_item.name_first, in_item.name_rest}));
        case (sort_mode)
            MODE_TID:  c.key = {41'd0, in_item.tid};
            MODE_NAME: c.key = '0;
            MODE_IO:   c.key = {1'b0, in_item.read_bytes} + {1'b0, in_item.write_bytes};
            default:   c.key = {1'b0, in_item.user_time} + {1'b0, in_item.system_time};
        endcase
    end

    assign full      = (cnt_reg == 2'd2);
    assign acc       = push && !full;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rp_reg];

    always_comb
    begin
        wp_next  = acc ? ~wp_reg : wp_reg;
        rp_next  = (cmd_take && cmd_valid) ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, acc} - {1'b0, cmd_take && cmd_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc) begin
            q_reg[wp_reg] <= c;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("command queue overfilled");
    assert property (@(posedge clk) disable iff (!rst_n)
        (full && !(cmd_take && cmd_valid)) |=> full)
        else $error("full dropped without a take");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> !cmd_valid)
        else $error("valid command from empty queue");

endmodule

// ===== hdl/strt_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strt_back
// Executes commands against the record memory and queues the results.
// ----------------------------------------------------------------------------
module strt_back #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_take,
    input  strt_pkg::cmd_t     cmd,
    output logic               empty,
    input  logic               pop,
    output strt_pkg::out_item_t out_item
);
    import strt_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    rec_t        mem [TABLE_DEPTH];
    rec_t        rd_reg;
    logic [AW-1:0] raddr;
    logic        ren;
    logic        wen;
    logic [AW-1:0] waddr;
    rec_t        wdata;

    bk_state_t   st_reg, st_next;
    cmd_t        c_reg, c_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] cur_reg, cur_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic        rdv_reg, rdv_next;
    logic        drop_reg, drop_next;
    logic [62:0] key_reg, key_next;
    logic        out_full_reg;
    out_item_t   out_reg, res;
    logic        res_we;

    logic        div_start;
    logic [47:0] div_q;
    logic        div_done;
    logic [47:0] skey_q;
    logic        sdiv_done;
    logic        sdiv_start;

    logic [62:0] skey;
    logic        ahead;

    strt_div u_div_new (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend(c_reg.rec.resident_size),
        .divisor({1'b0, c_reg.rec.user_time} + {1'b0, c_reg.rec.system_time}),
        .done(div_done), .quotient(div_q)
    );

    strt_div u_div_old (
        .clk(clk), .rst_n(rst_n), .start(sdiv_start),
        .dividend(rd_reg.resident_size),
        .divisor({1'b0, rd_reg.user_time} + {1'b0, rd_reg.system_time}),
        .done(sdiv_done), .quotient(skey_q)
    );

    always_comb
    begin
        case (c_reg.mode)
            MODE_TID: skey = {41'd0, rd_reg.tid};
            MODE_IO:  skey = {1'b0, rd_reg.read_bytes} + {1'b0, rd_reg.write_bytes};
            MODE_MEM: skey = {15'd0, skey_q};
            MODE_NAME: skey = '0;
            default:  skey = {1'b0, rd_reg.user_time} + {1'b0, rd_reg.system_time};
        endcase
        case (c_reg.mode)
            MODE_TID:  ahead = key_reg < skey;
            MODE_NAME: ahead = c_reg.name <
                               trim_name(fold_name({rd_reg.name_first, rd_reg.name_rest}));
            default:   ahead = key_reg > skey;
        endcase
    end

    always_comb
    begin
        st_next    = st_reg;
        c_next     = c_reg;
        count_next = count_reg;
        cur_next   = cur_reg;
        k_next     = k_reg;
        pos_next   = pos_reg;
        rdv_next   = 1'b0;
        drop_next  = drop_reg;
        key_next   = key_reg;
        div_start  = 1'b0;
        sdiv_start = 1'b0;
        case (st_reg)
            BK_IDLE:
            begin
                if (cmd_valid && !out_full_reg) begin
                    c_next = cmd;
                    key_next = cmd.key;
                    drop_next = (cmd.op == OP_INSERT) && (count_reg == CW'(TABLE_DEPTH));
                    case (cmd.op)
                        OP_INSERT:
                        begin
                            if (count_reg == CW'(TABLE_DEPTH)) begin
                                st_next = BK_DONE;
                            end else if (cmd.mode == MODE_MEM) begin
                                st_next = BK_KEY;
                                k_next  = '1;
                            end else begin
                                st_next = BK_SCAN;
                                k_next  = '0;
                            end
                        end
                        OP_WALK:
                        begin
                            if (cmd.restart) begin
                                cur_next = '0;
                            end
                            st_next = BK_READ;
                        end
                        default: st_next = BK_DONE;
                    endcase
                end
            end
            BK_KEY:
            begin
                div_start = (k_reg == '1);
                k_next    = '0;
                if (div_done) begin
                    key_next = {15'd0, div_q};
                    k_next   = '0;
                    st_next  = BK_SCAN;
                end
            end
            BK_SCAN:
            begin
                // Phase: k_reg read issued, rdv marks data ready next cycle.
                if (k_reg >= count_reg) begin
                    pos_next = count_reg;
                    k_next   = count_reg;
                    st_next  = BK_SHIFT;
                end else if (!rdv_reg) begin
                    rdv_next = 1'b1;
                    if (c_reg.mode == MODE_MEM) begin
                        pos_next = '1;
                    end
                end else if (c_reg.mode == MODE_MEM && pos_reg == '1) begin
                    sdiv_start = 1'b1;
                    pos_next   = '0;
                    rdv_next   = 1'b1;
                end else if (c_reg.mode == MODE_MEM && !sdiv_done) begin
                    rdv_next = 1'b1;
                end else if (ahead) begin
                    pos_next = k_reg;
                    k_next   = count_reg;
                    st_next  = BK_SHIFT;
                end else begin
                    k_next = k_reg + CW'(1);
                end
            end
            BK_SHIFT:
            begin
                if (k_reg == pos_reg) begin
                    st_next = BK_WRITE;
                end else if (!rdv_reg) begin
                    rdv_next = 1'b1;
                end else begin
                    k_next = k_reg - CW'(1);
                end
            end
            BK_WRITE:
            begin
                count_next = count_reg + CW'(1);
                st_next    = BK_DONE;
            end
            BK_READ:
            begin
                if (cur_reg > count_reg) begin
                    cur_next = count_reg;
                end
                if (!rdv_reg && cur_reg < count_reg) begin
                    rdv_next = 1'b1;
                end else begin
                    rdv_next = rdv_reg;
                    if (cur_reg < count_reg) begin
                        cur_next = cur_reg + CW'(1);
                    end
                    st_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (c_reg.op == OP_FLUSH) begin
                    count_next = '0;
                    cur_next   = '0;
                end
                st_next = BK_IDLE;
            end
            default: st_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        ren   = 1'b0;
        raddr = '0;
        wen   = 1'b0;
        waddr = '0;
        wdata = c_reg.rec;
        case (st_reg)
            BK_SCAN:
            begin
                ren   = !rdv_reg;
                raddr = k_reg[AW-1:0];
            end
            BK_SHIFT:
            begin
                ren   = !rdv_reg && (k_reg != pos_reg);
                raddr = AW'(k_reg - CW'(1));
                wen   = rdv_reg;
                waddr = k_reg[AW-1:0];
                wdata = rd_reg;
            end
            BK_WRITE:
            begin
                wen   = 1'b1;
                waddr = pos_reg[AW-1:0];
            end
            BK_READ:
            begin
                ren   = !rdv_reg;
                raddr = cur_reg[AW-1:0];
            end
            default: ren = 1'b0;
        endcase
    end

    always_comb
    begin
        res    = '0;
        res_we = (st_reg == BK_DONE);
        if (c_reg.op == OP_INSERT) begin
            res.insert_dropped = drop_reg;
        end
        if (c_reg.op == OP_WALK && rdv_reg) begin
            res.entry_valid       = 1'b1;
            res.out_tid           = rd_reg.tid;
            res.out_name_first    = rd_reg.name_first;
            res.out_name_rest     = rd_reg.name_rest;
            res.out_user_time     = rd_reg.user_time;
            res.out_system_time   = rd_reg.system_time;
            res.out_read_bytes    = rd_reg.read_bytes;
            res.out_write_bytes   = rd_reg.write_bytes;
            res.out_resident_size = rd_reg.resident_size;
        end
    end

    assign cmd_take = (st_reg == BK_IDLE) && cmd_valid && !out_full_reg;
    assign empty    = !out_full_reg;
    assign out_item = out_reg;

    always_ff @(posedge clk)
    begin
        if (ren) begin
            rd_reg <= mem[raddr];
        end
        if (wen) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg       <= BK_IDLE;
            count_reg    <= '0;
            cur_reg      <= '0;
            k_reg        <= '0;
            pos_reg      <= '0;
            rdv_reg      <= 1'b0;
            drop_reg     <= 1'b0;
            out_full_reg <= 1'b0;
        end else begin
            st_reg    <= st_next;
            count_reg <= count_next;
            cur_reg   <= cur_next;
            k_reg     <= k_next;
            pos_reg   <= (st_reg == BK_IDLE) ? '0 : pos_next;
            rdv_reg   <= rdv_next;
            drop_reg  <= drop_next;
            if (res_we) begin
                out_full_reg <= 1'b1;
            end else if (pop && out_full_reg) begin
                out_full_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg   <= c_next;
        key_reg <= key_next;
        if (res_we) begin
            out_reg <= res;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CW'(TABLE_DEPTH))
        else $error("record count beyond table depth");
    assert property (@(posedge clk) disable iff (!rst_n) cur_reg <= count_reg ||
        st_reg == BK_READ)
        else $error("walk cursor beyond record count");
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == BK_WRITE) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow the table");
    assert property (@(posedge clk) disable iff (!rst_n) res_we |-> !out_full_reg)
        else $error("result overwrote a waiting result");

endmodule
